FILE: hdl/session_link_selector_defines.svh
// Assertion macros for the session link selector.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef SESSION_LINK_SELECTOR_DEFINES_SVH
`define SESSION_LINK_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/slsel_pkg.sv
// Shared constants, types and codes for the session link selector.
// No dependencies; imported by every module of the block.
package slsel_pkg;

   localparam int MAX_CANDIDATES = 16;
   localparam int STAMP_BITS     = 32;

   // Stamps arrive as 32-bit fields and are kept modulo 2^STAMP_BITS.
   localparam int STAMP_W = (STAMP_BITS < 32) ? STAMP_BITS : 32;
   localparam int POS_W   = $clog2(MAX_CANDIDATES);
   localparam int CNT_W   = $clog2(MAX_CANDIDATES + 1);

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 16;

   localparam logic [1:0] REASON_RECV  = 2'd0;
   localparam logic [1:0] REASON_WRITE = 2'd1;
   localparam logic [1:0] REASON_CONN  = 2'd2;
   localparam logic [1:0] REASON_ANY   = 2'd3;

   localparam logic [1:0] COND_NONE  = 2'd0;
   localparam logic [1:0] COND_WRITE = 2'd1;
   localparam logic [1:0] COND_CONN  = 2'd2;
   localparam logic [1:0] COND_ERROR = 2'd3;

   typedef struct packed {
      logic               can_send;
      logic               has_link_error;
      logic [STAMP_W-1:0] receive_stamp;
      logic [STAMP_W-1:0] create_stamp;
      logic               last_item;
      logic               empty_list;
   } cand_type;

   typedef struct packed {
      logic       choice_valid;
      logic [3:0] chosen_index;
      logic [1:0] choice_reason;
      logic [1:0] peer_condition;
      logic       list_overflow;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]   item_count;
      logic               recv_found;
      logic [STAMP_W-1:0] recv_best_stamp;
      logic [POS_W-1:0]   recv_best_pos;
      logic               wr_found;
      logic [STAMP_W-1:0] wr_best_stamp;
      logic [POS_W-1:0]   wr_best_pos;
      logic               conn_found;
      logic [STAMP_W-1:0] conn_best_stamp;
      logic [POS_W-1:0]   conn_best_pos;
      logic [STAMP_W-1:0] any_best_stamp;
      logic [POS_W-1:0]   any_best_pos;
      logic               overflow_seen;
   } track_type;

endpackage

FILE: hdl/slsel_req_stage.sv
// Input register of the session link selector: captures one candidate item.
// Depends on slsel_pkg.
module slsel_req_stage
   import slsel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   input  logic                  consume,
   output logic                  cand_valid,
   output cand_type              cand
);

   logic     valid_ff, valid_in;
   cand_type cand_ff, cand_in;
   logic     accept;

   assign req_tready = !valid_ff || consume;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cand_in                = cand_ff;
      valid_in               = valid_ff;
      if (accept) begin
         cand_in.can_send       = req_tdata[0];
         cand_in.has_link_error = req_tdata[1];
         cand_in.receive_stamp  = STAMP_W'(req_tdata[33:2]);
         cand_in.create_stamp   = STAMP_W'(req_tdata[65:34]);
         cand_in.last_item      = req_tlast;
         cand_in.empty_list     = req_tuser[0];
         valid_in               = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cand_ff <= cand_in;
   end

   assign cand_valid = valid_ff;
   assign cand       = cand_ff;

endmodule

FILE: hdl/slsel_tracker.sv
// Running maxima over one candidate list and the choice made at its end.
// Depends on slsel_pkg.
module slsel_tracker
   import slsel_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  cand_type   cand,
   output result_type result
);

   track_type st_ff, st_in, upd;
   logic [POS_W-1:0] pos;
   logic             in_range;
   logic             recv_ok;

   always_comb begin
      pos      = st_ff.item_count[POS_W-1:0];
      in_range = st_ff.item_count < CNT_W'(MAX_CANDIDATES);
      recv_ok  = cand.receive_stamp != '0;
      upd      = st_ff;

      if (in_range) begin
         // Only a strictly greater stamp replaces the held one, so ties keep
         // the earliest position.
         if (cand.can_send && recv_ok &&
             (!st_ff.recv_found || cand.receive_stamp > st_ff.recv_best_stamp)) begin
            upd.recv_found      = 1'b1;
            upd.recv_best_stamp = cand.receive_stamp;
            upd.recv_best_pos   = pos;
         end
         if (cand.can_send &&
             (!st_ff.wr_found || cand.create_stamp > st_ff.wr_best_stamp)) begin
            upd.wr_found      = 1'b1;
            upd.wr_best_stamp = cand.create_stamp;
            upd.wr_best_pos   = pos;
         end
         if (!cand.has_link_error &&
             (!st_ff.conn_found || cand.create_stamp > st_ff.conn_best_stamp)) begin
            upd.conn_found      = 1'b1;
            upd.conn_best_stamp = cand.create_stamp;
            upd.conn_best_pos   = pos;
         end
         if (st_ff.item_count == '0 || cand.create_stamp > st_ff.any_best_stamp) begin
            upd.any_best_stamp = cand.create_stamp;
            upd.any_best_pos   = pos;
         end
         upd.item_count = st_ff.item_count + CNT_W'(1);
      end else begin
         upd.overflow_seen = 1'b1;
      end

      result                = '0;
      if (!cand.empty_list) begin
         result.choice_valid   = 1'b1;
         result.list_overflow  = upd.overflow_seen;
         result.peer_condition = upd.wr_found ? COND_WRITE :
                                 (upd.conn_found ? COND_CONN : COND_ERROR);
         if (upd.recv_found) begin
            result.chosen_index  = 4'(upd.recv_best_pos);
            result.choice_reason = REASON_RECV;
         end else if (upd.wr_found) begin
            result.chosen_index  = 4'(upd.wr_best_pos);
            result.choice_reason = REASON_WRITE;
         end else if (upd.conn_found) begin
            result.chosen_index  = 4'(upd.conn_best_pos);
            result.choice_reason = REASON_CONN;
         end else begin
            result.chosen_index  = 4'(upd.any_best_pos);
            result.choice_reason = REASON_ANY;
         end
      end

      st_in = st_ff;
      if (step) begin
         st_in = (cand.empty_list || cand.last_item) ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

FILE: hdl/slsel_rsp_stage.sv
// Result register of the session link selector: holds one result item.
// Depends on slsel_pkg.
module slsel_rsp_stage
   import slsel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            result,
   output logic                  free,
   output result_type            held,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign held       = res_ff;
   assign rsp_tdata  = {6'b0, res_ff.list_overflow, res_ff.peer_condition,
                        res_ff.choice_reason, res_ff.chosen_index, res_ff.choice_valid};

endmodule

FILE: hdl/session_link_selector.sv
// Top level of the session link selector: input register, list tracker and
// result register. Depends on slsel_pkg and session_link_selector_defines.svh.
//
//   channel | direction | carries
//   req_    | in        | one session candidate per item, tlast ends a list
//   rsp_    | out       | one choice per finished list
//
// One candidate item is accepted per clock. Each item waits in the input
// register; the running maxima are updated at the edge where it leaves, and a
// list's result is loaded into the result register at that same edge, from
// where it is offered on rsp_. A request stalls only when an item ending a list
// waits while the result register is full and not being taken. Reset is
// synchronous and clears all list state.
`include "session_link_selector_defines.svh"

module session_link_selector
   import slsel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] can_send, [1] has_link_error, [33:2] receive_stamp,
   // [65:34] create_stamp, [71:66] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] empty_list
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] choice_valid, [4:1] chosen_index, [6:5] choice_reason,
   // [8:7] peer_condition, [9] list_overflow, [15:10] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       cand_valid;
   cand_type   cand;
   logic       produces;
   logic       consume;
   logic       rsp_free;
   result_type result;
   result_type held;

   // An item that ends a list (last or empty) needs room in the result
   // register; any other item moves on into the tracker at once.
   assign produces = cand.last_item || cand.empty_list;
   assign consume  = cand_valid && (!produces || rsp_free);

   slsel_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .consume    (consume),
      .cand_valid (cand_valid),
      .cand       (cand)
   );

   slsel_tracker u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (consume),
      .cand   (cand),
      .result (result)
   );

   slsel_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && produces),
      .result     (result),
      .free       (rsp_free),
      .held       (held),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A result appears only after an item that ends a list has left the input.
   `SLS_ASSERT_NOW(a_rsp_from_list_end, clock, reset, $rose(rsp_tvalid),
      $past(consume && produces), "result appeared without a list end")
   // A list end that leaves the input always shows up in the result register.
   `SLS_ASSERT_NEXT(a_list_end_loads, clock, reset, consume && produces, rsp_tvalid,
      "list end did not load a result")
   // Back-pressure on requests comes only from a waiting list end.
   `SLS_ASSERT_NOW(a_stall_cause, clock, reset, !req_tready,
      cand_valid && produces && !rsp_free, "request stalled without cause")
   // A result for an empty list carries no choice.
   `SLS_ASSERT_NOW(a_empty_result, clock, reset, rsp_tvalid && !held.choice_valid,
      held.chosen_index == 4'd0 && held.choice_reason == REASON_RECV &&
      held.peer_condition == COND_NONE && !held.list_overflow,
      "empty list result not cleared")

endmodule

FILE: test/tb_session_link_selector.sv
// Self-checking testbench for session_link_selector: drives candidate lists on
// the request stream and checks every choice on the response stream.
// Depends on slsel_pkg and the session_link_selector RTL only.
module tb_session_link_selector;
   import slsel_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int TARGET_ITEMS  = 1950;
   // Once fewer than this many candidates wait to be sent, both sides stop
   // idling so the run ends with a stretch at full rate.
   localparam int QUIET_TAIL    = 250;
   // Cycles without any handshake before the run is declared hung. The worst
   // legal quiet stretch is a sender gap behind a result stall plus the pipeline,
   // so this leaves a wide margin.
   localparam int HANG_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;

   // A candidate waiting to be sent. When drain_first is set, the sender holds
   // it back until every outstanding choice has been returned.
   typedef struct {
      cand_type cand;
      bit       drain_first;
   } pending_cand_type;

   // Running state of the list being gathered, kept by the testbench itself.
   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic               recent_hit;    // writable with a receive stamp
      logic [STAMP_W-1:0] recent_stamp;
      logic [POS_W-1:0]   recent_pos;
      logic               writer_hit;    // writable at all
      logic [STAMP_W-1:0] writer_stamp;
      logic [POS_W-1:0]   writer_pos;
      logic               live_hit;      // no link error
      logic [STAMP_W-1:0] live_stamp;
      logic [POS_W-1:0]   live_pos;
      logic [STAMP_W-1:0] newest_stamp;  // every candidate
      logic [POS_W-1:0]   newest_pos;
      logic               spilled;       // list ran past MAX_CANDIDATES
   } list_state_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   pending_cand_type candidate_q[$];
   result_type       pending_choices[$];
   list_state_type   list_state = '0;
   cand_type         driven_cand = '0;  // the candidate currently on req_tdata
   bit               req_took = 1'b0;   // request handshake at the last rising edge
   int               req_gap_left = 0;
   int               rsp_stall_left = 0;
   int               quiet_cycles = 0;
   int               mismatch_count = 0;

   session_link_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Folds one accepted candidate into the running maxima. Returns 1 and the
   // choice when the item closes a list (by tlast or as an empty list).
   // Only a strictly greater stamp displaces the held winner, so ties keep
   // the earliest position.
   function automatic bit track_candidate(input cand_type c, output result_type choice);
      logic [POS_W-1:0] pos;
      choice = '0;
      if (c.empty_list) begin
         // An empty list throws away whatever was gathered and answers with
         // an all-zero choice, whatever tlast says.
         list_state = '0;
         return 1'b1;
      end
      if (list_state.count < MAX_CANDIDATES) begin
         pos = list_state.count[POS_W-1:0];
         if (c.can_send && c.receive_stamp != '0 &&
             (!list_state.recent_hit || c.receive_stamp > list_state.recent_stamp)) begin
            list_state.recent_hit   = 1'b1;
            list_state.recent_stamp = c.receive_stamp;
            list_state.recent_pos   = pos;
         end
         if (c.can_send &&
             (!list_state.writer_hit || c.create_stamp > list_state.writer_stamp)) begin
            list_state.writer_hit   = 1'b1;
            list_state.writer_stamp = c.create_stamp;
            list_state.writer_pos   = pos;
         end
         if (!c.has_link_error &&
             (!list_state.live_hit || c.create_stamp > list_state.live_stamp)) begin
            list_state.live_hit   = 1'b1;
            list_state.live_stamp = c.create_stamp;
            list_state.live_pos   = pos;
         end
         // The first candidate always seeds the fallback, even with stamp 0.
         if (list_state.count == '0 || c.create_stamp > list_state.newest_stamp) begin
            list_state.newest_stamp = c.create_stamp;
            list_state.newest_pos   = pos;
         end
         list_state.count = list_state.count + CNT_W'(1);
      end else begin
         // Candidates past the bound only mark the list as overflowed.
         list_state.spilled = 1'b1;
      end
      if (!c.last_item)
         return 1'b0;

      choice.choice_valid   = 1'b1;
      choice.list_overflow  = list_state.spilled;
      choice.peer_condition = list_state.writer_hit ? COND_WRITE :
                              list_state.live_hit   ? COND_CONN  : COND_ERROR;
      if (list_state.recent_hit) begin
         choice.chosen_index  = 4'(list_state.recent_pos);
         choice.choice_reason = REASON_RECV;
      end else if (list_state.writer_hit) begin
         choice.chosen_index  = 4'(list_state.writer_pos);
         choice.choice_reason = REASON_WRITE;
      end else if (list_state.live_hit) begin
         choice.chosen_index  = 4'(list_state.live_pos);
         choice.choice_reason = REASON_CONN;
      end else begin
         choice.chosen_index  = 4'(list_state.newest_pos);
         choice.choice_reason = REASON_ANY;
      end
      list_state = '0;
      return 1'b1;
   endfunction

   function automatic string show_choice(input result_type r);
      return $sformatf("valid=%0d index=%0d reason=%0d condition=%0d overflow=%0d",
                       r.choice_valid, r.chosen_index, r.choice_reason,
                       r.peer_condition, r.list_overflow);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic add_cand(input bit w, input bit err, input logic [31:0] rs,
                           input logic [31:0] cs, input bit last, input bit empty,
                           input bit drain = 1'b0);
      pending_cand_type p;
      p.cand.can_send       = w;
      p.cand.has_link_error = err;
      p.cand.receive_stamp  = rs;
      p.cand.create_stamp   = cs;
      p.cand.last_item      = last;
      p.cand.empty_list     = empty;
      p.drain_first         = drain;
      candidate_q.push_back(p);
   endtask

   // Stamp styles: a tiny range forces ties and zero receive stamps, the full
   // range toggles every bit, and the edge style sits on both ends.
   function automatic logic [31:0] pick_stamp(input int style);
      case (style)
         0: return 32'($urandom_range(0, 3));
         1: return $urandom;
         2: case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'h0000_0001;
               2:       return 32'hFFFF_FFFE;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : $urandom;
      endcase
   endfunction

   // One random list with random content. Most lists are short, some fill
   // the bound and a few run past it. Now and then an empty-list item lands
   // in the middle and cuts the list short.
   task automatic add_random_list(input bit drain);
      int n, sel, style, w_pct, e_pct;
      bit first;
      sel   = $urandom_range(0, 99);
      n     = (sel < 60) ? $urandom_range(1, 5) :
              (sel < 90) ? $urandom_range(6, 16) : $urandom_range(17, 20);
      style = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0:       w_pct = 0;
         1:       w_pct = 20;
         2:       w_pct = 50;
         default: w_pct = 90;
      endcase
      e_pct = ($urandom_range(0, 2) == 0) ? 95 : $urandom_range(0, 60);
      first = drain;
      if ($urandom_range(0, 19) == 0) begin
         add_cand(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'b1, first);
         return;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0)
            add_cand(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                     $urandom, 1'($urandom_range(0, 1)), 1'b1, first);
         else
            add_cand($urandom_range(0, 99) < w_pct, $urandom_range(0, 99) < e_pct,
                     pick_stamp(style), pick_stamp(style), i == n - 1, 1'b0, first);
         first = 1'b0;
      end
   endtask

   // Driver: both inputs of the block change only at the falling edge. The
   // result side stalls in bursts; the request side leaves gaps in bursts and
   // holds a marked candidate back until all choices are home.
   always @(negedge clock) begin
      pending_cand_type nxt;
      bit               tail;
      tail = candidate_q.size() < QUIET_TAIL;

      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!tail && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end

      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_tvalid <= 1'b0;
         end else if (candidate_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (candidate_q[0].drain_first && pending_choices.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (!tail && $urandom_range(0, 11) == 0) begin
            req_gap_left = $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else begin
            nxt = candidate_q.pop_front();
            driven_cand <= nxt.cand;
            req_tdata   <= {6'b0, nxt.cand.create_stamp, nxt.cand.receive_stamp,
                            nxt.cand.has_link_error, nxt.cand.can_send};
            req_tuser   <= nxt.cand.empty_list;
            req_tlast   <= nxt.cand.last_item;
            req_tvalid  <= 1'b1;
         end
      end
   end

   // Monitor: samples both handshakes at the rising edge, predicts a choice
   // for each accepted candidate and checks each returned choice in order.
   // It also guards against a hang.
   always @(posedge clock) begin
      result_type got, want, fresh;
      bit         moved;
      req_took <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got.choice_valid   = rsp_tdata[0];
            got.chosen_index   = rsp_tdata[4:1];
            got.choice_reason  = rsp_tdata[6:5];
            got.peer_condition = rsp_tdata[8:7];
            got.list_overflow  = rsp_tdata[9];
            if (pending_choices.size() == 0) begin
               report_mismatch({"unexpected choice: ", show_choice(got)});
            end else begin
               want = pending_choices.pop_front();
               if (got.choice_valid   !== want.choice_valid   ||
                   got.chosen_index   !== want.chosen_index   ||
                   got.choice_reason  !== want.choice_reason  ||
                   got.peer_condition !== want.peer_condition ||
                   got.list_overflow  !== want.list_overflow)
                  report_mismatch({"choice mismatch: expected ", show_choice(want),
                                   ", got ", show_choice(got)});
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            if (track_candidate(driven_cand, fresh))
               pending_choices.push_back(fresh);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, HANG_LIMIT);
            $display("session_link_selector regression: fail");
            $finish;
         end
      end
   end

   initial begin
      // Directed lists first.
      // Empty list without tlast, and with its other fields all ones.
      add_cand(1'b1, 1'b1, '1, '1, 1'b0, 1'b1);
      // Single writable candidate that never received: newest writable.
      add_cand(1'b1, 1'b0, 32'd0, 32'd5, 1'b1, 1'b0);
      // Single writable candidate at the top stamps: recent receive.
      add_cand(1'b1, 1'b1, '1, '1, 1'b1, 1'b0);
      // Not writable, link up: newest connecting; its receive stamp is ignored.
      add_cand(1'b0, 1'b0, '1, 32'd0, 1'b1, 1'b0);
      // Not writable, link down: error fallback at position 0.
      add_cand(1'b0, 1'b1, 32'd0, 32'd0, 1'b1, 1'b0);
      // Tied receive stamps: the earliest position wins.
      add_cand(1'b1, 1'b0, 32'd7, 32'd1, 1'b0, 1'b0);
      add_cand(1'b1, 1'b0, 32'd7, 32'd9, 1'b0, 1'b0);
      add_cand(1'b1, 1'b0, 32'd7, 32'd9, 1'b1, 1'b0);
      // All links down: newest create stamp, earliest of the tie.
      add_cand(1'b0, 1'b1, 32'd3, 32'd0, 1'b0, 1'b0);
      add_cand(1'b0, 1'b1, 32'd3, '1, 1'b0, 1'b0);
      add_cand(1'b0, 1'b1, 32'd3, '1, 1'b1, 1'b0);
      // Connecting candidates behind a failed one.
      add_cand(1'b0, 1'b1, 32'd0, '1, 1'b0, 1'b0);
      add_cand(1'b0, 1'b0, 32'd0, 32'd3, 1'b0, 1'b0);
      add_cand(1'b0, 1'b0, 32'd0, 32'd3, 1'b1, 1'b0);
      // A list cut short by an empty-list item that also carries tlast.
      add_cand(1'b1, 1'b0, 32'd9, 32'd2, 1'b0, 1'b0);
      add_cand(1'b1, 1'b0, 32'd10, 32'd2, 1'b0, 1'b0);
      add_cand(1'b1, 1'b0, 32'd1, 32'd1, 1'b1, 1'b1);
      // Receive stamp zero does not count as a receive.
      add_cand(1'b1, 1'b0, 32'd0, 32'd0, 1'b0, 1'b0);
      add_cand(1'b1, 1'b0, 32'd1, 32'd0, 1'b1, 1'b0);

      // Random lists; two of them wait until the block has gone quiet.
      for (int lists = 0; candidate_q.size() < TARGET_ITEMS; lists++)
         add_random_list(lists == 30 || lists == 250);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (candidate_q.size() == 0 && !req_tvalid);
      wait (pending_choices.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("session_link_selector regression: pass");
      else
         $display("session_link_selector regression: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/slsel_pkg.sv
hdl/slsel_req_stage.sv
hdl/slsel_tracker.sv
hdl/slsel_rsp_stage.sv
hdl/session_link_selector.sv
test/tb_session_link_selector.sv
